// File: rtl/evm_sse_pkg.sv
// Shared constants, types and opcode decode for the EVM stack effect engine.
`default_nettype none

package evm_sse_pkg;

    // Stack geometry.
    localparam int StackDepth = 1024;
    localparam int AddrW      = $clog2(StackDepth);
    localparam int CntW       = $clog2(StackDepth + 1);

    // Payload geometry.
    localparam int NumLanes = 4;
    localparam int LaneW    = 64;
    localparam int OpW      = 8;
    localparam int StatusW  = 2;
    localparam int DepthW   = 11;

    // Result status codes.
    localparam logic [StatusW-1:0] StOk      = 2'd0;
    localparam logic [StatusW-1:0] StUnknown = 2'd1;
    localparam logic [StatusW-1:0] StUnder   = 2'd2;
    localparam logic [StatusW-1:0] StOver    = 2'd3;

    // Opcode ranges with special handling.
    localparam logic [OpW-1:0] OpPush1    = 8'h60;
    localparam logic [OpW-1:0] OpPush32   = 8'h7f;
    localparam logic [OpW-1:0] OpDup1     = 8'h80;
    localparam logic [OpW-1:0] OpDup16    = 8'h8f;
    localparam logic [OpW-1:0] OpSwap1    = 8'h90;
    localparam logic [OpW-1:0] OpSwap16   = 8'h9f;
    localparam logic [OpW-1:0] OpDupBase  = 8'h7f;
    localparam logic [OpW-1:0] OpSwapBase = 8'h8e;

    // Source of the word written to a lane memory or loaded into the top register.
    typedef enum logic [1:0] {SelPush, SelZero, SelRd, SelTop} t_sel;

    // Per-beat command from the controller to every lane.
    typedef struct packed {
        logic             rd_en;
        logic [AddrW-1:0] rd_addr;
        logic             wr_en;
        logic [AddrW-1:0] wr_addr;
        t_sel             sel;
        logic             top_ld;
        logic             push_ld;
    } t_lane_ctl;

    // Completion report from the controller to the output stage.
    typedef struct packed {
        logic               valid;
        logic [StatusW-1:0] status;
        logic [CntW-1:0]    count;
    } t_done;

    // Decoded stack effect of one opcode.
    typedef struct packed {
        logic       known;
        logic [2:0] pops;
        logic       push;
    } t_dec;

    function automatic t_dec decode(input logic [OpW-1:0] op);
        t_dec d;
        d = {1'b1, 3'd0, 1'b0};
        if (op inside {[OpPush1:OpPush32]}) begin
            d = {1'b1, 3'd0, 1'b1};
        end else if (op inside {[OpDup1:OpSwap16]}) begin
            d = {1'b1, 3'd0, 1'b0};
        end else begin
            case (op)
                8'h00, 8'h5b, 8'hfe: d = {1'b1, 3'd0, 1'b0};
                8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h0a, 8'h0b,
                8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h16, 8'h17, 8'h18, 8'h1a,
                8'h20: d = {1'b1, 3'd2, 1'b1};
                8'h08, 8'h09, 8'hf0: d = {1'b1, 3'd3, 1'b1};
                8'h15, 8'h19, 8'h31, 8'h35, 8'h3b, 8'h40, 8'h51, 8'h54:
                    d = {1'b1, 3'd1, 1'b1};
                8'h30, 8'h32, 8'h33, 8'h34, 8'h36, 8'h38, 8'h3a, 8'h3d, 8'h41,
                8'h42, 8'h43, 8'h44, 8'h45, 8'h58, 8'h59, 8'h5a:
                    d = {1'b1, 3'd0, 1'b1};
                8'h37, 8'h39, 8'h3e, 8'ha1: d = {1'b1, 3'd3, 1'b0};
                8'h3c, 8'ha2: d = {1'b1, 3'd4, 1'b0};
                8'h50, 8'h56, 8'hff: d = {1'b1, 3'd1, 1'b0};
                8'h52, 8'h53, 8'h55, 8'h57, 8'ha0, 8'hf3, 8'hfd:
                    d = {1'b1, 3'd2, 1'b0};
                8'ha3: d = {1'b1, 3'd5, 1'b0};
                8'ha4: d = {1'b1, 3'd6, 1'b0};
                8'hf1, 8'hf2: d = {1'b1, 3'd7, 1'b1};
                8'hf4, 8'hfa: d = {1'b1, 3'd6, 1'b1};
                default: d = {1'b0, 3'd0, 1'b0};
            endcase
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// File: rtl/evm_sse_if.sv
// Valid/ready channel interfaces for instruction beats and result beats.
`default_nettype none

interface evm_sse_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [evm_sse_pkg::OpW-1:0]          opcode;
    logic [evm_sse_pkg::LaneW-1:0]        push_lane0;
    logic [evm_sse_pkg::LaneW-1:0]        push_lane1;
    logic [evm_sse_pkg::LaneW-1:0]        push_lane2;
    logic [evm_sse_pkg::LaneW-1:0]        push_lane3;

    modport source (output valid, opcode, push_lane0, push_lane1, push_lane2, push_lane3,
                    input ready);
    modport sink   (input valid, opcode, push_lane0, push_lane1, push_lane2, push_lane3,
                    output ready);
endinterface

interface evm_sse_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [evm_sse_pkg::StatusW-1:0]      status;
    logic [evm_sse_pkg::DepthW-1:0]       depth;
    logic [evm_sse_pkg::LaneW-1:0]        top_lane0;
    logic [evm_sse_pkg::LaneW-1:0]        top_lane1;
    logic [evm_sse_pkg::LaneW-1:0]        top_lane2;
    logic [evm_sse_pkg::LaneW-1:0]        top_lane3;

    modport source (output valid, status, depth, top_lane0, top_lane1, top_lane2, top_lane3,
                    input ready);
    modport sink   (input valid, status, depth, top_lane0, top_lane1, top_lane2, top_lane3,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/evm_sse_lane.sv
// One 64-bit lane of the operand stack: lane memory, read register, push and top registers.
`default_nettype none

module evm_sse_lane (
    input  wire logic                          i_clk,
    input  wire evm_sse_pkg::t_lane_ctl        i_ctl,
    input  wire logic [evm_sse_pkg::LaneW-1:0] i_push,
    output logic [evm_sse_pkg::LaneW-1:0]      o_top
);

    logic [evm_sse_pkg::LaneW-1:0] r_mem [evm_sse_pkg::StackDepth];
    logic [evm_sse_pkg::LaneW-1:0] r_rd;
    logic [evm_sse_pkg::LaneW-1:0] r_push;
    logic [evm_sse_pkg::LaneW-1:0] r_top;
    logic [evm_sse_pkg::LaneW-1:0] data;

    always_comb begin
        case (i_ctl.sel)
            evm_sse_pkg::SelPush: data = r_push;
            evm_sse_pkg::SelZero: data = '0;
            evm_sse_pkg::SelRd:   data = r_rd;
            evm_sse_pkg::SelTop:  data = r_top;
            default:              data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.wr_addr] <= data;
        end
        if (i_ctl.rd_en) begin
            r_rd <= r_mem[i_ctl.rd_addr];
        end
        if (i_ctl.push_ld) begin
            r_push <= i_push;
        end
        if (i_ctl.top_ld) begin
            r_top <= data;
        end
    end

    assign o_top = r_top;

endmodule

`default_nettype wire

// File: rtl/evm_sse_ctrl.sv
// Opcode decode, stack bound checks and the per-instruction sequencer that drives all lanes.
`default_nettype none

module evm_sse_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [evm_sse_pkg::OpW-1:0] i_opcode,
    input  wire logic                        i_out_free,
    output logic                             o_ready,
    output evm_sse_pkg::t_lane_ctl           o_ctl,
    output evm_sse_pkg::t_done               o_done
);

    localparam int CW = evm_sse_pkg::CntW;
    localparam int AW = evm_sse_pkg::AddrW;
    localparam logic [CW:0] DepthLim = (CW + 1)'(evm_sse_pkg::StackDepth);

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SWAP2} t_state;
    typedef enum logic [2:0] {K_ERR, K_NOP, K_PUSH, K_ZERO, K_POP, K_DUP, K_SWAP} t_kind;

    t_state                        r_state, n_state;
    t_kind                         r_kind, n_kind;
    logic [CW-1:0]                 r_count, n_count;
    logic [CW-1:0]                 r_cnt_new, n_cnt_new;
    logic [evm_sse_pkg::StatusW-1:0] r_status, n_status;
    logic [AW-1:0]                 r_wa1, n_wa1;
    logic [AW-1:0]                 r_wa2, n_wa2;
    logic                          r_top_upd, n_top_upd;

    evm_sse_pkg::t_dec             dec;
    logic                          accept;
    logic                          is_push, is_dup, is_swap;
    logic [CW:0]                   cnt_w, k_w, pops_w, push_w, s_w, m_w, mm1_w, t_w, sum_w;
    t_kind                         acc_kind;
    logic [evm_sse_pkg::StatusW-1:0] acc_status;
    logic [CW-1:0]                 acc_cnt;
    logic [AW-1:0]                 acc_rd, acc_wa1;
    logic                          acc_rd_en, acc_top_upd;

    // No beat is taken while reset is held, since the sequencer would drop it.
    assign o_ready = i_rst_n && (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // Decode and bound checks for the beat being offered.
    always_comb begin
        dec     = evm_sse_pkg::decode(i_opcode);
        is_push = i_opcode inside {[evm_sse_pkg::OpPush1:evm_sse_pkg::OpPush32]};
        is_dup  = i_opcode inside {[evm_sse_pkg::OpDup1:evm_sse_pkg::OpDup16]};
        is_swap = i_opcode inside {[evm_sse_pkg::OpSwap1:evm_sse_pkg::OpSwap16]};
        cnt_w   = {1'b0, r_count};
        pops_w  = (CW + 1)'(dec.pops);
        push_w  = (CW + 1)'(dec.push);
        if (is_dup) begin
            k_w = (CW + 1)'(i_opcode - evm_sse_pkg::OpDupBase);
        end else begin
            k_w = (CW + 1)'(i_opcode - evm_sse_pkg::OpSwapBase);
        end
        s_w   = cnt_w - k_w;
        t_w   = cnt_w - (CW + 1)'(1);
        m_w   = cnt_w - pops_w;
        mm1_w = m_w - (CW + 1)'(1);
        sum_w = m_w + push_w;

        acc_status  = evm_sse_pkg::StOk;
        acc_kind    = K_ERR;
        acc_cnt     = r_count;
        acc_rd_en   = 1'b0;
        acc_rd      = s_w[AW-1:0];
        acc_wa1     = m_w[AW-1:0];
        acc_top_upd = 1'b0;

        if (!dec.known) begin
            acc_status = evm_sse_pkg::StUnknown;
        end else if (is_dup) begin
            if (cnt_w < k_w) begin
                acc_status = evm_sse_pkg::StUnder;
            end else if (cnt_w >= DepthLim) begin
                acc_status = evm_sse_pkg::StOver;
            end else begin
                acc_kind  = K_DUP;
                acc_cnt   = CW'(cnt_w + (CW + 1)'(1));
                acc_rd_en = 1'b1;
                acc_wa1   = r_count[AW-1:0];
            end
        end else if (is_swap) begin
            if (cnt_w < k_w) begin
                acc_status = evm_sse_pkg::StUnder;
            end else begin
                acc_kind  = K_SWAP;
                acc_rd_en = 1'b1;
                acc_wa1   = s_w[AW-1:0];
            end
        end else if (cnt_w < pops_w) begin
            acc_status = evm_sse_pkg::StUnder;
        end else if (sum_w > DepthLim) begin
            acc_status = evm_sse_pkg::StOver;
        end else begin
            acc_cnt = sum_w[CW-1:0];
            if (is_push) begin
                acc_kind = K_PUSH;
            end else if (dec.push) begin
                acc_kind = K_ZERO;
            end else if (dec.pops != 3'd0) begin
                // The new top must be fetched unless the stack empties.
                acc_kind    = K_POP;
                acc_rd_en   = (m_w != '0);
                acc_top_upd = (m_w != '0);
                acc_rd      = mm1_w[AW-1:0];
            end else begin
                acc_kind = K_NOP;
            end
        end
    end

    // Sequencer and lane commands.
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_count   = r_count;
        n_cnt_new = r_cnt_new;
        n_status  = r_status;
        n_wa1     = r_wa1;
        n_wa2     = r_wa2;
        n_top_upd = r_top_upd;

        o_ctl.rd_en   = accept && acc_rd_en;
        o_ctl.rd_addr = acc_rd;
        o_ctl.push_ld = accept;
        o_ctl.wr_en   = 1'b0;
        o_ctl.wr_addr = r_wa1;
        o_ctl.sel     = evm_sse_pkg::SelZero;
        o_ctl.top_ld  = 1'b0;

        o_done.valid  = 1'b0;
        o_done.status = r_status;
        o_done.count  = r_cnt_new;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state   = S_EXEC;
                    n_kind    = acc_kind;
                    n_cnt_new = acc_cnt;
                    n_status  = acc_status;
                    n_wa1     = acc_wa1;
                    n_wa2     = t_w[AW-1:0];
                    n_top_upd = acc_top_upd;
                end
            end
            S_EXEC: begin
                if (r_kind == K_SWAP) begin
                    // Old top goes down to the deeper slot first.
                    o_ctl.wr_en = 1'b1;
                    o_ctl.sel   = evm_sse_pkg::SelTop;
                    n_state     = S_SWAP2;
                end else if (i_out_free) begin
                    o_done.valid = 1'b1;
                    n_count      = r_cnt_new;
                    n_state      = S_IDLE;
                    case (r_kind)
                        K_PUSH: begin
                            o_ctl.wr_en  = 1'b1;
                            o_ctl.top_ld = 1'b1;
                            o_ctl.sel    = evm_sse_pkg::SelPush;
                        end
                        K_ZERO: begin
                            o_ctl.wr_en  = 1'b1;
                            o_ctl.top_ld = 1'b1;
                            o_ctl.sel    = evm_sse_pkg::SelZero;
                        end
                        K_DUP: begin
                            o_ctl.wr_en  = 1'b1;
                            o_ctl.top_ld = 1'b1;
                            o_ctl.sel    = evm_sse_pkg::SelRd;
                        end
                        K_POP: begin
                            o_ctl.top_ld = r_top_upd;
                            o_ctl.sel    = evm_sse_pkg::SelRd;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SWAP2: begin
                if (i_out_free) begin
                    o_ctl.wr_en   = 1'b1;
                    o_ctl.wr_addr = r_wa2;
                    o_ctl.sel     = evm_sse_pkg::SelRd;
                    o_ctl.top_ld  = 1'b1;
                    o_done.valid  = 1'b1;
                    n_count       = r_cnt_new;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_kind    <= n_kind;
            r_cnt_new <= n_cnt_new;
            r_status  <= n_status;
            r_wa1     <= n_wa1;
            r_wa2     <= n_wa2;
            r_top_upd <= n_top_upd;
        end
    end

endmodule

`default_nettype wire

// File: rtl/evm_stack_effect_engine_top.sv
// Top level of the EVM stack effect engine: controller, four stack lanes and the result stage.
// An accepted instruction completes in the execute state, SWAP in a second state after it, once
// the result register is free; its result beat is then registered. No new instruction is taken
// until the last one completes: the lane memories have one write port, and SWAP needs two writes.
// Reset (synchronous, active low) empties the stack, drops any pending result and holds the
// input ready low; stack memory contents are not cleared and are never read before being written.
`default_nettype none

module evm_stack_effect_engine_top (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    evm_sse_in_if.sink     i_in,
    evm_sse_out_if.source  o_out
);

    // The controller decodes each instruction beat, checks it against the entry count and
    // sequences the lane memories. Each lane holds one 64-bit slice of every stack word, so
    // all four lanes run the same command in lockstep. The result stage at the bottom merges
    // the controller's status and count with the lanes' top-of-stack slices.

    evm_sse_pkg::t_lane_ctl         ctl;
    evm_sse_pkg::t_done             done;
    logic                           out_free;
    logic [evm_sse_pkg::LaneW-1:0]  lane_push [evm_sse_pkg::NumLanes];
    logic [evm_sse_pkg::LaneW-1:0]  lane_top  [evm_sse_pkg::NumLanes];

    logic                                         r_out_valid;
    logic [evm_sse_pkg::StatusW-1:0]              r_out_status;
    logic [evm_sse_pkg::CntW-1:0]                 r_out_cnt;
    logic [evm_sse_pkg::CntW+evm_sse_pkg::DepthW-1:0] cnt_ext;
    logic                                         top_nz;

    assign lane_push[0] = i_in.push_lane0;
    assign lane_push[1] = i_in.push_lane1;
    assign lane_push[2] = i_in.push_lane2;
    assign lane_push[3] = i_in.push_lane3;

    evm_sse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .i_opcode   (i_in.opcode),
        .i_out_free (out_free),
        .o_ready    (i_in.ready),
        .o_ctl      (ctl),
        .o_done     (done)
    );

    for (genvar g = 0; g < evm_sse_pkg::NumLanes; g++) begin : g_lane
        evm_sse_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_push (lane_push[g]),
            .o_top  (lane_top[g])
        );
    end

    // The result register frees up when its beat is taken in the same cycle, so a finishing
    // instruction never waits on a consumer that keeps ready high.
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (done.valid) begin
                r_out_valid  <= 1'b1;
                r_out_status <= done.status;
                r_out_cnt    <= done.count;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The lanes' top registers only change when an instruction completes, which the
    // controller holds back until the result register is free, so they stay steady for as
    // long as a result beat waits. An empty stack reports zero in every lane.
    assign cnt_ext = (evm_sse_pkg::CntW + evm_sse_pkg::DepthW)'(r_out_cnt);
    assign top_nz  = (r_out_cnt != '0);

    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.depth     = cnt_ext[evm_sse_pkg::DepthW-1:0];
    assign o_out.top_lane0 = top_nz ? lane_top[0] : '0;
    assign o_out.top_lane1 = top_nz ? lane_top[1] : '0;
    assign o_out.top_lane2 = top_nz ? lane_top[2] : '0;
    assign o_out.top_lane3 = top_nz ? lane_top[3] : '0;

endmodule

`default_nettype wire

// File: rtl/evm_sse_checker.sv
// Port-level checks on the result channel of the EVM stack effect engine, bound to the top.
`default_nettype none

module evm_sse_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_valid,
    input wire logic                              i_ready,
    input wire logic [evm_sse_pkg::StatusW-1:0]   i_status,
    input wire logic [evm_sse_pkg::DepthW-1:0]    i_depth,
    input wire logic [evm_sse_pkg::LaneW-1:0]     i_top0,
    input wire logic [evm_sse_pkg::LaneW-1:0]     i_top1,
    input wire logic [evm_sse_pkg::LaneW-1:0]     i_top2,
    input wire logic [evm_sse_pkg::LaneW-1:0]     i_top3
);

    localparam bit DepthFits = evm_sse_pkg::StackDepth < (1 << evm_sse_pkg::DepthW);

    // No result beat survives a reset.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !i_valid)
        else $error("result beat offered right after reset");

    // A stalled result beat holds its whole payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_depth)
            && $stable(i_top0) && $stable(i_top1) && $stable(i_top2) && $stable(i_top3))
        else $error("stalled result beat changed");

    // An empty stack shows a zero top word.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DepthFits && i_valid && i_depth == '0 |->
            i_top0 == '0 && i_top1 == '0 && i_top2 == '0 && i_top3 == '0)
        else $error("empty stack reports a nonzero top");

    // Overflow can only be reported with the stack full.
    a_over_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status == evm_sse_pkg::StOver |->
            i_depth == evm_sse_pkg::DepthW'(evm_sse_pkg::StackDepth))
        else $error("overflow reported below full depth");

endmodule

bind evm_stack_effect_engine_top evm_sse_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_status (o_out.status),
    .i_depth  (o_out.depth),
    .i_top0   (o_out.top_lane0),
    .i_top1   (o_out.top_lane1),
    .i_top2   (o_out.top_lane2),
    .i_top3   (o_out.top_lane3)
);

`default_nettype wire
